### rtl/julian_day_to_calendar_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Julian day to calendar converter
// Shared concurrent assertion forms, all sampled on the rising clock edge
// and disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef JULIAN_DAY_TO_CALENDAR_MACROS_SVH
`define JULIAN_DAY_TO_CALENDAR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JDC_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold once the delay n has passed since the antecedent.
`define JDC_ASSERT_DELAY(name, clk, rst_n, ante, n, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##(n) (cons)) \
        else $error(msg);

`endif

### rtl/jdc_pkg.sv
// ----------------------------------------------------------------------------
// jdc_pkg
// Types, constants and tables shared by the Julian day to calendar pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package jdc_pkg;

    // Pipeline depth from an accepted item to its result strobe.
    localparam int LATENCY = 10;

    // Port field types.
    typedef logic [21:0]        t_day_number;
    typedef logic [31:0]        t_day_fraction;
    typedef logic signed [13:0] t_year;
    typedef logic [3:0]         t_month;
    typedef logic [4:0]         t_mday;
    typedef logic [4:0]         t_hour;
    typedef logic [5:0]         t_minute;
    typedef logic [21:0]        t_seconds;
    typedef logic [2:0]         t_week_day;

    // First day number counted in the Gregorian calendar.
    localparam t_day_number GREG_START = 22'd2299161;

    // Century correction: b = (4a - B_OFFSET) / B_DIV.
    localparam logic [23:0] B_OFFSET = 24'd7468865;
    localparam int          B_DIV    = 146097;
    localparam int          B_SHIFT  = 30;
    localparam logic [12:0] B_RECIP  = 13'((longint'(1) << B_SHIFT) / B_DIV);

    // Offsets that form c from the day number.
    localparam logic [22:0] JUL_OFFSET  = 23'd1524;
    localparam logic [22:0] GREG_OFFSET = 23'd1525;

    // Year count: d = (20c - D_OFFSET) / D_DIV.
    localparam logic [26:0] D_OFFSET = 27'd2442;
    localparam int          D_DIV    = 7305;
    localparam int          D_SHIFT  = 27;
    localparam logic [14:0] D_RECIP  = 15'((longint'(1) << D_SHIFT) / D_DIV);

    // Year origin of the method.
    localparam logic [14:0] YEAR_OFFSET = 15'd4715;

    // Month boundaries: entry f is floor(30.6001 * f).
    localparam logic [9:0] MONTH_START [16] = '{
        10'd0,   10'd30,  10'd61,  10'd91,  10'd122, 10'd153, 10'd183, 10'd214,
        10'd244, 10'd275, 10'd306, 10'd336, 10'd367, 10'd397, 10'd428, 10'd459
    };

endpackage

`default_nettype wire

### rtl/jdc_date.sv
// ----------------------------------------------------------------------------
// jdc_date
// Ten-stage date pipeline: day number to year, month and day of month.
// ----------------------------------------------------------------------------
`default_nettype none

module jdc_date (
    input  wire logic              i_clk,
    input  wire jdc_pkg::t_day_number i_day_number,
    output jdc_pkg::t_year         o_cal_year,
    output jdc_pkg::t_month        o_cal_month,
    output jdc_pkg::t_mday         o_cal_day
);

    // Stage 1: calendar select and century dividend.
    jdc_pkg::t_day_number r_s1_a, n_s1_a;
    logic                 r_s1_greg, n_s1_greg;
    logic [23:0]          r_s1_xb, n_s1_xb;

    // Stage 2: reciprocal estimate of the century count.
    jdc_pkg::t_day_number r_s2_a;
    logic                 r_s2_greg;
    logic [23:0]          r_s2_xb;
    logic [6:0]           r_s2_bq, n_s2_bq;
    logic [36:0]          w2_pb;

    // Stage 3: corrected century count.
    jdc_pkg::t_day_number r_s3_a;
    logic                 r_s3_greg;
    logic [6:0]           r_s3_b, n_s3_b;
    logic [24:0]          w3_prod;
    logic [24:0]          w3_rem;

    // Stage 4: shifted day count c.
    logic [22:0]          r_s4_c, n_s4_c;

    // Stage 5: year dividend.
    logic [22:0]          r_s5_c;
    logic [26:0]          r_s5_xd, n_s5_xd;

    // Stage 6: reciprocal estimate of the year count.
    logic [22:0]          r_s6_c;
    logic [26:0]          r_s6_xd;
    logic [13:0]          r_s6_dq, n_s6_dq;
    logic [41:0]          w6_pd;

    // Stage 7: corrected year count d.
    logic [22:0]          r_s7_c;
    logic [13:0]          r_s7_d, n_s7_d;
    logic [26:0]          w7_prod;
    logic [26:0]          w7_rem;

    // Stage 8: days left in the year.
    logic [13:0]          r_s8_d;
    logic [9:0]           r_s8_rest, n_s8_rest;
    logic [24:0]          w8_prod;
    logic [22:0]          w8_diff;

    // Stage 9: month index f.
    logic [13:0]          r_s9_d;
    logic [9:0]           r_s9_rest;
    logic [3:0]           r_s9_f, n_s9_f;
    logic [15:0]          w9_ge;

    // Stage 10: calendar fields.
    jdc_pkg::t_year       r_s10_year, n_s10_year;
    jdc_pkg::t_month      r_s10_month, n_s10_month;
    jdc_pkg::t_mday       r_s10_day, n_s10_day;
    logic [14:0]          w10_year;
    logic [9:0]           w10_day;

    always_comb begin
        // The dividend is only meaningful for Gregorian day numbers.
        n_s1_a    = i_day_number;
        n_s1_greg = (i_day_number >= jdc_pkg::GREG_START);
        n_s1_xb   = {i_day_number, 2'b00} - jdc_pkg::B_OFFSET;

        // The estimate is the true quotient or one below it.
        w2_pb   = 37'(r_s1_xb) * 37'(jdc_pkg::B_RECIP);
        n_s2_bq = w2_pb[36:jdc_pkg::B_SHIFT];

        // One compare against the divisor fixes the estimate.
        w3_prod = 25'(r_s2_bq) * 25'(jdc_pkg::B_DIV);
        w3_rem  = {1'b0, r_s2_xb} - w3_prod;
        n_s3_b  = r_s2_bq + 7'(w3_rem >= 25'(jdc_pkg::B_DIV));

        // The Julian calendar skips the century correction.
        if (r_s3_greg) begin
            n_s4_c = 23'(r_s3_a) + 23'(r_s3_b) - 23'(r_s3_b >> 2) + jdc_pkg::GREG_OFFSET;
        end else begin
            n_s4_c = 23'(r_s3_a) + jdc_pkg::JUL_OFFSET;
        end

        // Twenty times c, as sixteen plus four times.
        n_s5_xd = {r_s4_c, 4'b0000} + 27'({r_s4_c, 2'b00}) - jdc_pkg::D_OFFSET;

        w6_pd   = 42'(r_s5_xd) * 42'(jdc_pkg::D_RECIP);
        n_s6_dq = w6_pd[40:jdc_pkg::D_SHIFT];

        w7_prod = 27'(r_s6_dq) * 27'(jdc_pkg::D_DIV);
        w7_rem  = r_s6_xd - w7_prod;
        n_s7_d  = r_s6_dq + 14'(w7_rem >= 27'(jdc_pkg::D_DIV));

        // Subtract the whole days of the completed years, 365.25 per year.
        w8_prod   = 25'(r_s7_d) * 25'd1461;
        w8_diff   = r_s7_c - w8_prod[24:2];
        n_s8_rest = w8_diff[9:0];

        // The boundary compares form a thermometer code; search it in four steps.
        // No boundary 30.6001 * f with f above zero is a whole number, so the rest
        // reaches it only when it is strictly above the floor.
        for (int k = 0; k < 16; k++) begin
            w9_ge[k] = (r_s8_rest > jdc_pkg::MONTH_START[k]);
        end
        n_s9_f[3] = w9_ge[8];
        n_s9_f[2] = w9_ge[{n_s9_f[3], 3'b100}];
        n_s9_f[1] = w9_ge[{n_s9_f[3], n_s9_f[2], 2'b10}];
        n_s9_f[0] = w9_ge[{n_s9_f[3], n_s9_f[2], n_s9_f[1], 1'b1}];

        // Months count from March; January and February close the year.
        if (r_s9_f < 4'd14) begin
            n_s10_month = r_s9_f - 4'd1;
        end else begin
            n_s10_month = r_s9_f - 4'd13;
        end
        w10_day    = r_s9_rest - jdc_pkg::MONTH_START[r_s9_f];
        n_s10_day  = w10_day[4:0];
        w10_year   = 15'(r_s9_d) - jdc_pkg::YEAR_OFFSET - 15'(n_s10_month > 4'd2);
        n_s10_year = w10_year[13:0];
    end

    always_ff @(posedge i_clk) begin
        r_s1_a      <= n_s1_a;
        r_s1_greg   <= n_s1_greg;
        r_s1_xb     <= n_s1_xb;
        r_s2_a      <= r_s1_a;
        r_s2_greg   <= r_s1_greg;
        r_s2_xb     <= r_s1_xb;
        r_s2_bq     <= n_s2_bq;
        r_s3_a      <= r_s2_a;
        r_s3_greg   <= r_s2_greg;
        r_s3_b      <= n_s3_b;
        r_s4_c      <= n_s4_c;
        r_s5_c      <= r_s4_c;
        r_s5_xd     <= n_s5_xd;
        r_s6_c      <= r_s5_c;
        r_s6_xd     <= r_s5_xd;
        r_s6_dq     <= n_s6_dq;
        r_s7_c      <= r_s6_c;
        r_s7_d      <= n_s7_d;
        r_s8_d      <= r_s7_d;
        r_s8_rest   <= n_s8_rest;
        r_s9_d      <= r_s8_d;
        r_s9_rest   <= r_s8_rest;
        r_s9_f      <= n_s9_f;
        r_s10_year  <= n_s10_year;
        r_s10_month <= n_s10_month;
        r_s10_day   <= n_s10_day;
    end

    assign o_cal_year  = r_s10_year;
    assign o_cal_month = r_s10_month;
    assign o_cal_day   = r_s10_day;

endmodule

`default_nettype wire

### rtl/jdc_tod.sv
// ----------------------------------------------------------------------------
// jdc_tod
// Time-of-day pipeline: day fraction to hour, minute and Q6.16 seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module jdc_tod (
    input  wire logic                 i_clk,
    input  wire jdc_pkg::t_day_fraction i_day_fraction,
    output jdc_pkg::t_hour            o_cal_hour,
    output jdc_pkg::t_minute          o_cal_minute,
    output jdc_pkg::t_seconds         o_cal_seconds
);

    typedef struct packed {
        jdc_pkg::t_hour    hour;
        jdc_pkg::t_minute  minute;
        jdc_pkg::t_seconds seconds;
    } t_tod;

    localparam int DLY_DEPTH = jdc_pkg::LATENCY - 2;

    // Stage 1: hours and the rest of the hour.
    jdc_pkg::t_hour   r_s1_hour, n_s1_hour;
    logic [31:0]      r_s1_rem, n_s1_rem;
    logic [36:0]      w1_t;

    // Stage 2: minutes and the rest of the minute.
    jdc_pkg::t_hour   r_s2_hour;
    jdc_pkg::t_minute r_s2_minute, n_s2_minute;
    logic [31:0]      r_s2_rem, n_s2_rem;
    logic [37:0]      w2_t;

    // Stage 3 onward: finished time, delayed to line up with the date.
    logic [37:0]      w3_t;
    t_tod             r_dly [DLY_DEPTH];
    t_tod             n_dly [DLY_DEPTH];

    always_comb begin
        w1_t      = 37'(i_day_fraction) * 37'd24;
        n_s1_hour = w1_t[36:32];
        n_s1_rem  = w1_t[31:0];

        w2_t        = 38'(r_s1_rem) * 38'd60;
        n_s2_minute = w2_t[37:32];
        n_s2_rem    = w2_t[31:0];

        // Seconds keep sixteen fraction bits and drop the rest.
        w3_t               = 38'(r_s2_rem) * 38'd60;
        n_dly[0].hour      = r_s2_hour;
        n_dly[0].minute    = r_s2_minute;
        n_dly[0].seconds   = w3_t[37:16];
        for (int j = 1; j < DLY_DEPTH; j++) begin
            n_dly[j] = r_dly[j - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_hour   <= n_s1_hour;
        r_s1_rem    <= n_s1_rem;
        r_s2_hour   <= r_s1_hour;
        r_s2_minute <= n_s2_minute;
        r_s2_rem    <= n_s2_rem;
        r_dly       <= n_dly;
    end

    assign o_cal_hour    = r_dly[DLY_DEPTH - 1].hour;
    assign o_cal_minute  = r_dly[DLY_DEPTH - 1].minute;
    assign o_cal_seconds = r_dly[DLY_DEPTH - 1].seconds;

endmodule

`default_nettype wire

### rtl/jdc_wday.sv
// ----------------------------------------------------------------------------
// jdc_wday
// Weekday pipeline: (day number + 1) mod 7 by octal digit sums.
// ----------------------------------------------------------------------------
`default_nettype none

module jdc_wday (
    input  wire logic                 i_clk,
    input  wire jdc_pkg::t_day_number i_day_number,
    output jdc_pkg::t_week_day        o_week_day
);

    localparam int DLY_DEPTH = jdc_pkg::LATENCY - 1;

    // Stage 1: sum of the octal digits, congruent mod 7 since 8 is 1 mod 7.
    logic [23:0]          w1_num;
    logic [5:0]           r_s1_sum, n_s1_sum;

    // Stage 2 onward: folded residue, delayed to line up with the date.
    logic [3:0]           w2_fold;
    logic [3:0]           w2_fold2;
    jdc_pkg::t_week_day   r_dly [DLY_DEPTH];
    jdc_pkg::t_week_day   n_dly [DLY_DEPTH];

    always_comb begin
        w1_num   = 24'(i_day_number) + 24'd1;
        n_s1_sum = 6'd0;
        for (int k = 0; k < 8; k++) begin
            n_s1_sum = n_s1_sum + 6'(w1_num[3 * k +: 3]);
        end

        // Fold twice more, then map a residue of seven to zero.
        w2_fold  = 4'(r_s1_sum[5:3]) + 4'(r_s1_sum[2:0]);
        w2_fold2 = 4'(w2_fold[3]) + 4'(w2_fold[2:0]);
        if (w2_fold2 >= 4'd7) begin
            n_dly[0] = 3'(w2_fold2 - 4'd7);
        end else begin
            n_dly[0] = w2_fold2[2:0];
        end
        for (int j = 1; j < DLY_DEPTH; j++) begin
            n_dly[j] = r_dly[j - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sum <= n_s1_sum;
        r_dly    <= n_dly;
    end

    assign o_week_day = r_dly[DLY_DEPTH - 1];

endmodule

`default_nettype wire

### rtl/julian_day_to_calendar.sv
// ----------------------------------------------------------------------------
// julian_day_to_calendar
// Pipelined conversion of a Julian day number and day fraction to a date.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge where start is high and busy is low. It
// carries an integer Julian day number and the elapsed fraction of the day
// since midnight in units of 2^-32 day.
// At the last stage o_strobe is high for one cycle, with year, month, day of
// month, hour, minute, Q6.16 seconds and weekday (0 is Sunday) on the result
// ports. The receiver takes every result in that cycle and cannot hold it off.
// One item is taken every cycle; busy is low whenever reset is released.
// The latency is set by the date path: two reciprocal divisions, each a
// multiply stage followed by a correction stage, plus the month search.
// Hour, minute and seconds come from three constant multiplications, and the
// weekday from octal digit folding; both are delayed to match the date.
// While i_rst_n is low, busy is high and all items in flight are dropped:
// no strobe follows for them.
// ----------------------------------------------------------------------------
`default_nettype none

`include "julian_day_to_calendar_macros.svh"

module julian_day_to_calendar (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire jdc_pkg::t_day_number   i_day_number,
    input  wire jdc_pkg::t_day_fraction i_day_fraction,
    output logic                        o_strobe,
    output jdc_pkg::t_year              o_cal_year,
    output jdc_pkg::t_month             o_cal_month,
    output jdc_pkg::t_mday              o_cal_day,
    output jdc_pkg::t_hour              o_cal_hour,
    output jdc_pkg::t_minute            o_cal_minute,
    output jdc_pkg::t_seconds           o_cal_seconds,
    output jdc_pkg::t_week_day          o_week_day
);

    logic w_accept;
    logic [jdc_pkg::LATENCY-1:0] r_vld, n_vld;

    // The pipeline never stalls, so only reset holds items off.
    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;

    // Valid bits march alongside the data stages.
    always_comb begin
        n_vld = {r_vld[jdc_pkg::LATENCY-2:0], w_accept};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_strobe = r_vld[jdc_pkg::LATENCY-1];

    // Date path.
    jdc_date u_date (
        .i_clk        (i_clk),
        .i_day_number (i_day_number),
        .o_cal_year   (o_cal_year),
        .o_cal_month  (o_cal_month),
        .o_cal_day    (o_cal_day)
    );

    // Time-of-day path.
    jdc_tod u_tod (
        .i_clk          (i_clk),
        .i_day_fraction (i_day_fraction),
        .o_cal_hour     (o_cal_hour),
        .o_cal_minute   (o_cal_minute),
        .o_cal_seconds  (o_cal_seconds)
    );

    // Weekday path.
    jdc_wday u_wday (
        .i_clk        (i_clk),
        .i_day_number (i_day_number),
        .o_week_day   (o_week_day)
    );

    // Every accepted item produces its strobe after the full pipeline depth.
    `JDC_ASSERT_DELAY(a_strobe_follows, i_clk, i_rst_n, w_accept, jdc_pkg::LATENCY, o_strobe, "accepted item lost")
    // A strobe only ever belongs to an accepted item.
    `JDC_ASSERT_IMPL(a_strobe_origin, i_clk, i_rst_n, o_strobe, $past(w_accept, jdc_pkg::LATENCY), "strobe without item")
    // Dates on a strobe are always well formed.
    `JDC_ASSERT_IMPL(a_date_range, i_clk, i_rst_n, o_strobe, (o_cal_month >= 4'd1) && (o_cal_month <= 4'd12) && (o_cal_day >= 5'd1), "date out of range")
    // Time of day and weekday on a strobe are within their ranges.
    `JDC_ASSERT_IMPL(a_time_range, i_clk, i_rst_n, o_strobe, (o_cal_hour <= 5'd23) && (o_cal_minute <= 6'd59) && (o_week_day <= 3'd6), "time out of range")

endmodule

`default_nettype wire

### verif/julian_day_to_calendar_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// julian_day_to_calendar_tb
// Self-checking bench for the Julian day to calendar converter. Each accepted
// item is converted by a behavioral copy of Meeus' method in the bench. The
// expected date and time of day are queued, and each result strobe is checked
// field by field against the oldest entry. Stimulus starts with the range
// limits and the Gregorian switch, then turns to random day numbers and
// fractions biased toward calendar and clock boundaries. Random sender gaps
// are used throughout, and some items wait until the pipeline has drained.
// ----------------------------------------------------------------------------

module julian_day_to_calendar_tb;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1880;

    // One item waiting to be sent, with an option to drain the pipeline first.
    typedef struct {
        jdc_pkg::t_day_number   day_number;
        jdc_pkg::t_day_fraction day_fraction;
        bit                     drain_first;
    } t_conversion_request;

    // Expected result, with the inputs kept for the error messages.
    typedef struct {
        jdc_pkg::t_day_number   day_number;
        jdc_pkg::t_day_fraction day_fraction;
        jdc_pkg::t_year         year;
        jdc_pkg::t_month        month;
        jdc_pkg::t_mday         mday;
        jdc_pkg::t_hour         hour;
        jdc_pkg::t_minute       minute;
        jdc_pkg::t_seconds      seconds;
        jdc_pkg::t_week_day     week_day;
    } t_calendar_date;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   start          = 1'b0;
    jdc_pkg::t_day_number   i_day_number   = '0;
    jdc_pkg::t_day_fraction i_day_fraction = '0;
    logic                   busy;
    logic                   o_strobe;
    jdc_pkg::t_year         o_cal_year;
    jdc_pkg::t_month        o_cal_month;
    jdc_pkg::t_mday         o_cal_day;
    jdc_pkg::t_hour         o_cal_hour;
    jdc_pkg::t_minute       o_cal_minute;
    jdc_pkg::t_seconds      o_cal_seconds;
    jdc_pkg::t_week_day     o_week_day;

    t_conversion_request pending_items[$];
    t_calendar_date      expected_dates[$];
    int                  error_count   = 0;
    int                  idle_left     = 0;
    int                  no_idle_run   = 0;
    int                  cycle_count   = 0;

    julian_day_to_calendar u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_day_number   (i_day_number),
        .i_day_fraction (i_day_fraction),
        .o_strobe       (o_strobe),
        .o_cal_year     (o_cal_year),
        .o_cal_month    (o_cal_month),
        .o_cal_day      (o_cal_day),
        .o_cal_hour     (o_cal_hour),
        .o_cal_minute   (o_cal_minute),
        .o_cal_seconds  (o_cal_seconds),
        .o_week_day     (o_week_day)
    );

    // Free-running 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Behavioral conversion: Meeus' method with every division done exactly.
    function automatic t_calendar_date predict_date(jdc_pkg::t_day_number dn,
                                                    jdc_pkg::t_day_fraction fr);
        t_calendar_date  res;
        longint unsigned jd, cent, shifted, yrs, yr_start, rem_days, mon_idx, mon;
        longint unsigned tod;
        longint          yr;
        jd = dn;
        if (jd < jdc_pkg::GREG_START) begin
            shifted = jd + 1524;
        end else begin
            // Drop the leap days that the Gregorian rule skips.
            cent    = (4 * jd - 64'd7468865) / 64'd146097;
            shifted = jd + cent - (cent >> 2) + 1525;
        end
        yrs      = (20 * shifted - 64'd2442) / 64'd7305;
        yr_start = (64'd1461 * yrs) >> 2;
        rem_days = shifted - yr_start;
        mon_idx  = (64'd10000 * rem_days) / 64'd306001;
        mon      = (mon_idx < 14) ? mon_idx - 1 : mon_idx - 13;
        yr       = longint'(yrs) - 4715 - ((mon > 2) ? 1 : 0);

        res.day_number   = dn;
        res.day_fraction = fr;
        res.year         = yr[13:0];
        res.month        = mon[3:0];
        res.mday         = jdc_pkg::t_mday'(rem_days - (64'd306001 * mon_idx) / 64'd10000);

        // Time of day: peel off hours, minutes and Q6.16 seconds in turn.
        tod          = longint'(fr) * 24;
        res.hour     = jdc_pkg::t_hour'(tod >> 32);
        tod          = (tod & 64'hFFFF_FFFF) * 60;
        res.minute   = jdc_pkg::t_minute'(tod >> 32);
        tod          = (tod & 64'hFFFF_FFFF) * 60;
        res.seconds  = jdc_pkg::t_seconds'(tod >> 16);
        res.week_day = jdc_pkg::t_week_day'((jd + 1) % 7);
        return res;
    endfunction

    // Sender idle time after an item: mostly none or short, a few long,
    // and now and then a long run of back-to-back items.
    function automatic int draw_sender_gap();
        int r;
        if (no_idle_run > 0) begin
            no_idle_run--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            no_idle_run = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random day number, weighted toward the calendar switch and the limits.
    function automatic jdc_pkg::t_day_number draw_day_number();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return jdc_pkg::t_day_number'($urandom_range(0, 22'h3F_FFFF));
        if (r < 50) begin
            return jdc_pkg::t_day_number'(int'(jdc_pkg::GREG_START) +
                                          $urandom_range(0, 1600) - 800);
        end
        if (r < 75) return jdc_pkg::t_day_number'($urandom_range(2415021, 2488070));
        if (r < 88) return jdc_pkg::t_day_number'($urandom_range(0, 5000));
        return jdc_pkg::t_day_number'(22'h3F_FFFF - $urandom_range(0, 5000));
    endfunction

    // Random fraction, weighted toward hour and minute boundaries.
    function automatic jdc_pkg::t_day_fraction draw_day_fraction();
        int              r;
        longint unsigned edge_point;
        r = $urandom_range(0, 99);
        if (r < 50) return jdc_pkg::t_day_fraction'($urandom());
        if (r < 70) begin
            edge_point = (longint'($urandom_range(0, 24)) << 32) / 24;
            return jdc_pkg::t_day_fraction'(edge_point + $urandom_range(0, 4) - 2);
        end
        if (r < 88) begin
            edge_point = (longint'($urandom_range(0, 1440)) << 32) / 1440;
            return jdc_pkg::t_day_fraction'(edge_point + $urandom_range(0, 4) - 2);
        end
        if (r < 94) return jdc_pkg::t_day_fraction'($urandom_range(0, 255));
        return jdc_pkg::t_day_fraction'(32'hFFFF_FFFF - $urandom_range(0, 255));
    endfunction

    function automatic void queue_item(jdc_pkg::t_day_number dn,
                                       jdc_pkg::t_day_fraction fr, bit drain);
        t_conversion_request req;
        req.day_number   = dn;
        req.day_fraction = fr;
        req.drain_first  = drain;
        pending_items.push_back(req);
    endfunction

    // Prints one line per failure and counts every one.
    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(t_calendar_date want, string name,
                               logic signed [23:0] got, logic signed [23:0] exp_val);
        if (got !== exp_val) begin
            report_error($sformatf("day %0d frac 0x%08h: %s is %0d, expected %0d",
                                   want.day_number, want.day_fraction, name, got, exp_val));
        end
    endtask

    // Stimulus: directed corners first, then the random mix.
    initial begin
        longint unsigned one_day;
        one_day = 64'h1_0000_0000;

        queue_item(22'd0, 32'h0000_0000, 1'b0);
        queue_item(22'h3F_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_item(22'd2299159, 32'h8000_0000, 1'b0);
        queue_item(22'd2299160, 32'hFFFF_FFFF, 1'b0);
        queue_item(22'd2299161, 32'h0000_0000, 1'b1);
        queue_item(22'd2299162, 32'h4000_0000, 1'b0);
        queue_item(22'd1721423, jdc_pkg::t_day_fraction'(one_day / 24), 1'b0);
        queue_item(22'd1721424, jdc_pkg::t_day_fraction'(one_day / 24 + 1), 1'b0);
        queue_item(22'd2415079, jdc_pkg::t_day_fraction'(one_day / 1440), 1'b0);
        queue_item(22'd2415080, jdc_pkg::t_day_fraction'(one_day / 1440 + 1), 1'b0);
        queue_item(22'd2451544, jdc_pkg::t_day_fraction'(one_day * 23 / 24), 1'b0);
        queue_item(22'd2451545, jdc_pkg::t_day_fraction'(one_day * 23 / 24 + 1), 1'b0);
        queue_item(22'd2451604, 32'hAAAA_AAAA, 1'b0);
        queue_item(22'd2451605, 32'h5555_5555, 1'b0);
        queue_item(22'h2A_AAAA, 32'h0000_0001, 1'b0);
        queue_item(22'h15_5555, 32'hFFFF_FFFE, 1'b0);
        queue_item(22'd1, jdc_pkg::t_day_fraction'(one_day * 1439 / 1440), 1'b0);
        queue_item(22'h3F_FFFE, jdc_pkg::t_day_fraction'(one_day * 1439 / 1440 + 1), 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            queue_item(draw_day_number(), draw_day_fraction(), (n % 400) == 399);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for everything to be sent and every result to come back.
        @(negedge i_clk);
        while (pending_items.size() > 0 || start || expected_dates.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (jdc_pkg::LATENCY + 5) @(negedge i_clk);

        if (error_count == 0) begin
            $display("julian_day_to_calendar_tb OK");
        end else begin
            $display("julian_day_to_calendar_tb NOT OK");
        end
        $finish;
    end

    // Sender: records each accepted item and presents the next after its gap.
    always @(posedge i_clk) begin
        t_conversion_request req;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_dates.push_back(predict_date(i_day_number, i_day_fraction));
                idle_left = draw_sender_gap();
            end
            if (!(start && busy)) begin
                if (idle_left > 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (pending_items.size() > 0 &&
                             !(pending_items[0].drain_first && expected_dates.size() > 0)) begin
                    req = pending_items.pop_front();
                    start          <= 1'b1;
                    i_day_number   <= req.day_number;
                    i_day_fraction <= req.day_fraction;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Receiver: every strobe must match the oldest outstanding item.
    always @(posedge i_clk) begin
        t_calendar_date want;
        if (i_rst_n && o_strobe) begin
            if (expected_dates.size() == 0) begin
                report_error("result strobe with no item outstanding");
            end else begin
                want = expected_dates.pop_front();
                check_field(want, "year",    o_cal_year,    want.year);
                check_field(want, "month",   o_cal_month,   want.month);
                check_field(want, "day",     o_cal_day,     want.mday);
                check_field(want, "hour",    o_cal_hour,    want.hour);
                check_field(want, "minute",  o_cal_minute,  want.minute);
                check_field(want, "seconds", o_cal_seconds, want.seconds);
                check_field(want, "weekday", o_week_day,    want.week_day);
            end
        end
    end

    // Watchdog against a hung handshake or a lost result.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_dates.size());
            $display("julian_day_to_calendar_tb NOT OK");
            $finish;
        end
    end

endmodule
